// ===== rtl/mwms_pkg.sv =====
// Shared widths, constants and types for the moving window mean/std block.
// No dependencies; every other file uses these through scoped names.
package mwms_pkg;

  localparam int SAMPLE_W   = 24;   // Q16.8 signed sample / mean
  localparam int STD_W      = 23;   // Q15.8 unsigned deviation
  localparam int HIST_DEPTH = 256;  // ring entries
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int WIN_W      = 9;    // window_length register
  localparam int WIN_RESET  = 20;
  localparam int SUM_W      = 32;   // running sum, signed
  localparam int SQ_W       = 56;   // running sum of squares
  localparam int ACC_W      = 64;   // products and radicand
  localparam int OP_W       = 32;   // multiplier / dividend / root width
  localparam int STEPS      = 32;   // iterations per serial operation
  localparam int CNT_W      = $clog2(STEPS);
  localparam int ROOT_REM_W = OP_W + 1;

  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam logic REG_WINDOW = 1'b0;  // paddr[2] of window_length

  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse when the result is ready
  } unit_stat_t;

endpackage

// ===== rtl/mwms_if.sv =====
// Ready/valid channel interfaces: sample beats in, result beats out.
// Depends on mwms_pkg for field widths.
interface mwms_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwms_pkg::SAMPLE_W-1:0] sample;
  logic                                series_start;

  modport source (output valid, sample, series_start, input ready);
  modport sink   (input valid, sample, series_start, output ready);
endinterface

interface mwms_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwms_pkg::SAMPLE_W-1:0] window_mean;
  logic        [mwms_pkg::STD_W-1:0]    window_std;
  logic                                result_valid;

  modport source (output valid, window_mean, window_std, result_valid, input ready);
  modport sink   (input valid, window_mean, window_std, result_valid, output ready);
endinterface

// ===== rtl/mwms_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle, product mod 2^64.
// Depends on mwms_pkg.
module mwms_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mwms_pkg::ACC_W-1:0]   mcand_i,
  input  logic [mwms_pkg::OP_W-1:0]    mplier_i,
  output logic [mwms_pkg::ACC_W-1:0]   prod_o,
  output mwms_pkg::unit_stat_t         stat_o
);

  logic                         busy_q, done_q;
  logic [mwms_pkg::CNT_W-1:0]   cnt_q;
  logic [mwms_pkg::ACC_W-1:0]   acc_q, mc_q;
  logic [mwms_pkg::OP_W-1:0]    mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mwms_pkg::CNT_W'(mwms_pkg::STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= mcand_i;
      mp_q  <= mplier_i;
    end else if (busy_q) begin
      if (mp_q[0]) acc_q <= acc_q + mc_q;
      mc_q <= {mc_q[mwms_pkg::ACC_W-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[mwms_pkg::OP_W-1:1]};
    end
  end

  assign prod_o = acc_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/mwms_div.sv =====
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 9-bit window.
// Depends on mwms_pkg.
module mwms_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mwms_pkg::OP_W-1:0]    dividend_i,
  input  logic [mwms_pkg::WIN_W-1:0]   divisor_i,
  output logic [mwms_pkg::OP_W-1:0]    quot_o,
  output mwms_pkg::unit_stat_t         stat_o
);

  logic                         busy_q, done_q;
  logic [mwms_pkg::CNT_W-1:0]   cnt_q;
  logic [mwms_pkg::OP_W-1:0]    q_q;
  logic [mwms_pkg::WIN_W-1:0]   rem_q, d_q;
  logic [mwms_pkg::WIN_W:0]     trial;
  logic                         ge;

  assign trial = {rem_q, q_q[mwms_pkg::OP_W-1]};
  assign ge    = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mwms_pkg::CNT_W'(mwms_pkg::STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_q <= ge ? mwms_pkg::WIN_W'(trial - {1'b0, d_q}) : trial[mwms_pkg::WIN_W-1:0];
      q_q   <= {q_q[mwms_pkg::OP_W-2:0], ge};
    end
  end

  assign quot_o = q_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/mwms_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle, floored.
// Depends on mwms_pkg.
module mwms_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mwms_pkg::ACC_W-1:0]   radicand_i,
  output logic [mwms_pkg::OP_W-1:0]    root_o,
  output mwms_pkg::unit_stat_t         stat_o
);

  localparam int RW = mwms_pkg::ROOT_REM_W;

  logic                         busy_q, done_q;
  logic [mwms_pkg::CNT_W-1:0]   cnt_q;
  logic [mwms_pkg::ACC_W-1:0]   n_q;
  logic [RW-1:0]                rem_q;
  logic [mwms_pkg::OP_W-1:0]    root_q;
  logic [RW+1:0]                r2, trial;
  logic                         ge;

  assign r2    = {rem_q, n_q[mwms_pkg::ACC_W-1 -: 2]};
  assign trial = (RW+2)'({root_q, 2'b01});
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mwms_pkg::CNT_W'(mwms_pkg::STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[mwms_pkg::ACC_W-3:0], 2'b00};
      // partial remainder never exceeds twice the partial root
      rem_q  <= ge ? RW'(r2 - trial) : r2[RW-1:0];
      root_q <= {root_q[mwms_pkg::OP_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/moving_window_mean_std.sv =====
// Moving window mean and population deviation: top level, ring memory, sequencer.
// Depends on mwms_pkg, mwms_if, mwms_mul, mwms_div, mwms_sqrt.
//
// Usage
//  in_i  : sample beats (signed Q16.8 sample, series_start). series_start
//          clears the window history and sums before its own sample.
//  out_o : one result beat per sample: window_mean, window_std and
//          result_valid. Until window_length samples have arrived in the
//          series, result_valid is 0 and mean/std read 0.
//  APB   : window_length at address 0, low 9 bits kept (0 acts as 1, above 256 as 256).
//          A write restarts the series. Write only while the block is idle.
// Timing
//  One sample at a time. A sample beat is taken only when the sequencer is
//  idle. Each serial step (multiply, divide, root) holds the sequencer
//  through start, 32 steps and done. A full window runs both squares, both
//  products, the root and both divides; the beat that fills the window skips
//  the square of a leaving sample (none leaves yet), and earlier beats run
//  only the new square. The sequencer returns to idle as the result is loaded.
//  The result sits in an output register, so the next sample is taken while
//  the receiver stalls; a further result waits in the sequencer until the
//  output register drains.
// Reset
//  Asynchronous, active low: window_length = 20, empty series, no result
//  pending. The ring memory itself is not cleared; only entries written in
//  the current series are ever read.
module moving_window_mean_std (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [mwms_pkg::APB_AW-1:0]   paddr_i,
  input  logic [mwms_pkg::APB_DW-1:0]   pwdata_i,
  output logic [mwms_pkg::APB_DW-1:0]   prdata_o,
  output logic                          pready_o,
  mwms_in_if.sink                       in_i,
  mwms_out_if.source                    out_o
);

  localparam int SW = mwms_pkg::SAMPLE_W;
  localparam int PW = mwms_pkg::PTR_W;
  localparam int WW = mwms_pkg::WIN_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;  // ring read data back, update sum
  localparam logic [3:0] S_SQN   = 4'd2;  // square of new sample
  localparam logic [3:0] S_SQO   = 4'd3;  // square of sample leaving window
  localparam logic [3:0] S_POST  = 4'd4;
  localparam logic [3:0] S_AW    = 4'd5;  // sumsq * W
  localparam logic [3:0] S_BB    = 4'd6;  // sum^2
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_DSTD  = 4'd8;
  localparam logic [3:0] S_DMEAN = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q;

  // configuration and series state
  logic [WW-1:0]                     wl_q, w_eff;
  logic [PW-1:0]                     wp_q, wp_eff, rd_addr;
  logic [WW-1:0]                     fill_q, fill_eff;
  logic signed [mwms_pkg::SUM_W-1:0] sum_q;
  logic [mwms_pkg::SQ_W-1:0]         sumsq_q;

  // per-sample working registers
  logic signed [SW-1:0]              s_q, old_q;
  logic                              old_en_q, valid_q;
  logic [mwms_pkg::ACC_W-1:0]        aw_q;
  logic signed [SW-1:0]              mean_q;
  logic [mwms_pkg::STD_W-1:0]        std_q;

  // output register
  logic                              out_valid_q;
  logic signed [SW-1:0]              out_mean_q;
  logic [mwms_pkg::STD_W-1:0]        out_std_q;
  logic                              out_rv_q;

  logic signed [SW-1:0]              ring [mwms_pkg::HIST_DEPTH];

  // serial units
  logic                              mul_start_q, div_start_q, sqrt_start_q;
  logic [mwms_pkg::ACC_W-1:0]        mul_a_q, sqrt_n_q, prod;
  logic [mwms_pkg::OP_W-1:0]         mul_b_q, div_n_q, quot, root;
  mwms_pkg::unit_stat_t              mul_st, div_st, sqrt_st;

  logic                              cfg_we, in_beat, out_beat, out_load;
  logic [SW-1:0]                     s_mag, old_mag;
  logic [mwms_pkg::OP_W-1:0]         sum_mag;

  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o
                    && (paddr_i[2] == mwms_pkg::REG_WINDOW);
  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_valid_q && out_o.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == mwms_pkg::REG_WINDOW)
                    ? mwms_pkg::APB_DW'(wl_q) : '0;

  always_comb begin
    if (wl_q == '0)                              w_eff = WW'(1);
    else if (wl_q > WW'(mwms_pkg::HIST_DEPTH))   w_eff = WW'(mwms_pkg::HIST_DEPTH);
    else                                         w_eff = wl_q;
  end

  assign wp_eff   = in_i.series_start ? '0 : wp_q;
  assign fill_eff = in_i.series_start ? '0 : fill_q;
  assign rd_addr  = wp_eff - w_eff[PW-1:0];   // full-depth window wraps onto wp

  assign s_mag   = s_q[SW-1]   ? SW'(-s_q)   : SW'(s_q);
  assign old_mag = old_q[SW-1] ? SW'(-old_q) : SW'(old_q);
  assign sum_mag = sum_q[mwms_pkg::SUM_W-1] ? mwms_pkg::OP_W'(-sum_q)
                                            : mwms_pkg::OP_W'(sum_q);

  // ring: read of the leaving sample and write of the new one share the edge
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      old_q         <= ring[rd_addr];
      ring[wp_eff]  <= in_i.sample;
      s_q           <= in_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wl_q         <= WW'(mwms_pkg::WIN_RESET);
      wp_q         <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      sumsq_q      <= '0;
      old_en_q     <= 1'b0;
      valid_q      <= 1'b0;
      mul_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      mul_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;

      if (out_load)      out_valid_q <= 1'b1;
      else if (out_beat) out_valid_q <= 1'b0;

      if (cfg_we) begin
        wl_q    <= pwdata_i[WW-1:0];
        wp_q    <= '0;
        fill_q  <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (in_beat) begin
              old_en_q <= (fill_eff >= w_eff);
              wp_q     <= wp_eff + 1'b1;
              fill_q   <= (fill_eff < w_eff) ? fill_eff + 1'b1 : w_eff;
              valid_q  <= (fill_eff + 1'b1 >= w_eff);
              if (in_i.series_start) begin
                sum_q   <= '0;
                sumsq_q <= '0;
              end
              state_q <= S_SUM;
            end
          end
          S_SUM: begin
            sum_q <= sum_q + mwms_pkg::SUM_W'(s_q)
                     - (old_en_q ? mwms_pkg::SUM_W'(old_q) : '0);
            mul_a_q     <= mwms_pkg::ACC_W'(s_mag);
            mul_b_q     <= mwms_pkg::OP_W'(s_mag);
            mul_start_q <= 1'b1;
            state_q     <= S_SQN;
          end
          S_SQN: begin
            if (mul_st.done) begin
              sumsq_q <= sumsq_q + prod[mwms_pkg::SQ_W-1:0];
              if (old_en_q) begin
                mul_a_q     <= mwms_pkg::ACC_W'(old_mag);
                mul_b_q     <= mwms_pkg::OP_W'(old_mag);
                mul_start_q <= 1'b1;
                state_q     <= S_SQO;
              end else begin
                state_q <= S_POST;
              end
            end
          end
          S_SQO: begin
            if (mul_st.done) begin
              sumsq_q <= sumsq_q - prod[mwms_pkg::SQ_W-1:0];
              state_q <= S_POST;
            end
          end
          S_POST: begin
            if (valid_q) begin
              mul_a_q     <= mwms_pkg::ACC_W'(sumsq_q);
              mul_b_q     <= mwms_pkg::OP_W'(w_eff);
              mul_start_q <= 1'b1;
              state_q     <= S_AW;
            end else begin
              mean_q  <= '0;
              std_q   <= '0;
              state_q <= S_DONE;
            end
          end
          S_AW: begin
            if (mul_st.done) begin
              aw_q        <= prod;
              mul_a_q     <= mwms_pkg::ACC_W'(sum_mag);
              mul_b_q     <= sum_mag;
              mul_start_q <= 1'b1;
              state_q     <= S_BB;
            end
          end
          S_BB: begin
            if (mul_st.done) begin
              // variance numerator W*sumsq - sum^2, clamped at zero
              sqrt_n_q     <= (aw_q > prod) ? aw_q - prod : '0;
              sqrt_start_q <= 1'b1;
              state_q      <= S_ROOT;
            end
          end
          S_ROOT: begin
            if (sqrt_st.done) begin
              div_n_q     <= root;
              div_start_q <= 1'b1;
              state_q     <= S_DSTD;
            end
          end
          S_DSTD: begin
            if (div_st.done) begin
              std_q       <= quot[mwms_pkg::STD_W-1:0];
              div_n_q     <= sum_mag;
              div_start_q <= 1'b1;
              state_q     <= S_DMEAN;
            end
          end
          S_DMEAN: begin
            if (div_st.done) begin
              mean_q  <= sum_q[mwms_pkg::SUM_W-1] ? SW'(-quot[SW-1:0]) : SW'(quot[SW-1:0]);
              state_q <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_load) state_q <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q <= mean_q;
      out_std_q  <= std_q;
      out_rv_q   <= valid_q;
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.window_mean  = out_mean_q;
  assign out_o.window_std   = out_std_q;
  assign out_o.result_valid = out_rv_q;

  mwms_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .mcand_i  (mul_a_q),
    .mplier_i (mul_b_q),
    .prod_o   (prod),
    .stat_o   (mul_st)
  );

  mwms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_n_q),
    .divisor_i  (w_eff),
    .quot_o     (quot),
    .stat_o     (div_st)
  );

  mwms_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start_q),
    .radicand_i (sqrt_n_q),
    .root_o     (root),
    .stat_o     (sqrt_st)
  );

  // fill count never runs past the window
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= w_eff)
    else $error("fill count beyond window");

  // a unit is never restarted while it works
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> !mul_st.busy)
    else $error("multiplier restarted while busy");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start_q |-> !sqrt_st.busy)
    else $error("root unit restarted while busy");

  // a result beat before the window fills carries zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_rv_q) |-> (out_mean_q == '0 && out_std_q == '0))
    else $error("nonzero fields on a partial-window beat");

  // an accepted sample moves the sequencer to the sum step unless a window write comes with it
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !cfg_we) |=> (state_q == S_SUM))
    else $error("sample beat not sequenced");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for moving_window_mean_std: random and directed sample beats,
// APB window writes between phases, in-bench window mean/deviation predictor.
// Depends on mwms_pkg, mwms_if and the RTL top level.
module tb_top;

  typedef struct packed {
    logic signed [mwms_pkg::SAMPLE_W-1:0] sample;
    logic                                 start;
  } sample_beat_t;

  typedef struct packed {
    logic signed [mwms_pkg::SAMPLE_W-1:0] mean;
    logic [mwms_pkg::STD_W-1:0]           std;
    logic                                 vld;
  } stat_beat_t;

  localparam logic signed [mwms_pkg::SAMPLE_W-1:0] SMP_MAX =
    {1'b0, {(mwms_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [mwms_pkg::SAMPLE_W-1:0] SMP_MIN =
    {1'b1, {(mwms_pkg::SAMPLE_W-1){1'b0}}};
  localparam int CYC_LIMIT = 4_000_000;
  localparam int DRAIN_CYC = 400;

  logic clk_i;
  logic rst_ni;
  logic psel_i, penable_i, pwrite_i;
  logic [mwms_pkg::APB_AW-1:0] paddr_i;
  logic [mwms_pkg::APB_DW-1:0] pwdata_i;
  logic [mwms_pkg::APB_DW-1:0] prdata_o;
  logic pready_o;

  mwms_in_if  in_if ();
  mwms_out_if out_if ();

  moving_window_mean_std dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Stimulus and scoreboard stores
  sample_beat_t pending_samples[$];
  stat_beat_t   expected_stats[$];
  int           err_count;
  int           send_idle_pct;   // percent of cycles the sender holds off
  int           recv_stall_pct;  // percent of cycles the receiver stalls

  // Predictor state: shadow of window history, sums and window register
  logic signed [mwms_pkg::SAMPLE_W-1:0] win_hist [mwms_pkg::HIST_DEPTH];
  int unsigned                wr_ptr;
  int unsigned                fill_cnt;
  longint                     sum_acc;
  bit [63:0]                  sumsq_acc;
  int unsigned                win_reg;

  function automatic bit [63:0] floor_sqrt(bit [63:0] n);
    bit [63:0] root;
    bit [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic bit [63:0] mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_window();
    wr_ptr    = 0;
    fill_cnt  = 0;
    sum_acc   = 0;
    sumsq_acc = 0;
  endfunction

  // Advance the shadow window by one sample and return the stats it yields.
  function automatic stat_beat_t window_stats(sample_beat_t beat);
    int unsigned w;
    int unsigned idx;
    longint      s;
    longint      old;
    longint      mean;
    bit [63:0]   a, b, n;
    stat_beat_t  r;
    w = (win_reg == 0) ? 1 : (win_reg > mwms_pkg::HIST_DEPTH) ? mwms_pkg::HIST_DEPTH
                                                               : win_reg;
    s = beat.sample;
    if (beat.start) clear_window();
    if (fill_cnt >= w) begin
      idx = (wr_ptr + mwms_pkg::HIST_DEPTH - w) % mwms_pkg::HIST_DEPTH;
      old = win_hist[mwms_pkg::PTR_W'(idx)];
      sum_acc   -= old;
      sumsq_acc -= mag(old) * mag(old);
    end
    sum_acc   += s;
    sumsq_acc += mag(s) * mag(s);
    win_hist[mwms_pkg::PTR_W'(wr_ptr)] = beat.sample;
    wr_ptr = (wr_ptr + 1) % mwms_pkg::HIST_DEPTH;
    if (fill_cnt < w) fill_cnt++;
    r = '0;
    if (fill_cnt >= w) begin
      mean = sum_acc / longint'(w);
      a = sumsq_acc * w;
      b = mag(sum_acc) * mag(sum_acc);
      n = (a > b) ? a - b : 0;
      r.mean = mean[mwms_pkg::SAMPLE_W-1:0];
      r.std  = mwms_pkg::STD_W'(floor_sqrt(n) / w);
      r.vld  = 1'b1;
    end
    return r;
  endfunction

  // Random sample: full range, extremes, a tight cluster, or a flat run
  function automatic sample_beat_t rand_sample(int start_pct);
    sample_beat_t beat;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40)
      beat.sample = mwms_pkg::SAMPLE_W'($urandom);
    else if (sel < 55)
      beat.sample = $urandom_range(1) ? SMP_MAX : SMP_MIN;
    else if (sel < 80)
      beat.sample = 24'sd2000 + $signed(24'($urandom_range(400))) - 24'sd200;
    else
      beat.sample = -24'sd77;
    beat.start = ($urandom_range(99) < start_pct);
    return beat;
  endfunction

  // Clock, with a global cycle limit as a hang guard
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : cycle_guard
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= CYC_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Driver: present queued sample beats, hold valid until accepted,
  // predict the result at the accepting edge.
  always @(posedge clk_i) begin : sample_driver
    logic         hold;
    sample_beat_t nxt;
    if (rst_ni) begin
      hold = in_if.valid && !in_if.ready;
      if (in_if.valid && in_if.ready)
        expected_stats.push_back(window_stats('{in_if.sample, in_if.series_start}));
      if (!hold) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_if.valid        <= 1'b1;
          in_if.sample       <= nxt.sample;
          in_if.series_start <= nxt.start;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : stat_monitor
    stat_beat_t exp_b;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_stats.size() == 0) begin
          $error("result beat with no prediction pending");
          err_count++;
        end else begin
          exp_b = expected_stats.pop_front();
          if (out_if.window_mean !== exp_b.mean) begin
            $error("window_mean exp %0d got %0d", exp_b.mean, out_if.window_mean);
            err_count++;
          end
          if (out_if.window_std !== exp_b.std) begin
            $error("window_std exp %0d got %0d", exp_b.std, out_if.window_std);
            err_count++;
          end
          if (out_if.result_valid !== exp_b.vld) begin
            $error("result_valid exp %0d got %0d", exp_b.vld, out_if.result_valid);
            err_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic apb_write(input logic [mwms_pkg::APB_AW-1:0] addr,
                           input logic [mwms_pkg::APB_DW-1:0] data);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    // register index is paddr/4; only window_length exists
    if (addr[mwms_pkg::APB_AW-1:2] == mwms_pkg::REG_WINDOW) begin
      win_reg = data & 32'h1FF;
      clear_window();
    end
  endtask

  // Wait until every queued beat went in and every prediction was matched,
  // then let the sequencer settle.
  task automatic drain();
    wait (pending_samples.size() == 0 && !in_if.valid && expected_stats.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  initial begin : main_seq
    int win_list [9];
    int cnt_list [9];
    int p;
    // everything known from time zero
    rst_ni             = 1'b0;
    psel_i             = 1'b0;
    penable_i          = 1'b0;
    pwrite_i           = 1'b0;
    paddr_i            = '0;
    pwdata_i           = '0;
    in_if.valid        = 1'b0;
    in_if.sample       = '0;
    in_if.series_start = 1'b0;
    out_if.ready       = 1'b0;
    err_count          = 0;
    win_reg            = mwms_pkg::WIN_RESET;
    clear_window();
    set_idling(0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A few beats at the reset window of 20, short of filling it
    for (int i = 0; i < 4; i++) pending_samples.push_back(rand_sample(0));
    drain();

    // Directed: window of 3, extremes, flat runs, restarts mid-window
    apb_write(3'd0, 32'd3);
    pending_samples.push_back('{SMP_MAX, 1'b1});
    pending_samples.push_back('{SMP_MAX, 1'b0});
    pending_samples.push_back('{SMP_MAX, 1'b0});
    pending_samples.push_back('{SMP_MIN, 1'b0});
    pending_samples.push_back('{SMP_MIN, 1'b0});
    pending_samples.push_back('{SMP_MIN, 1'b0});
    pending_samples.push_back('{SMP_MAX, 1'b0});
    pending_samples.push_back('{SMP_MIN, 1'b0});
    pending_samples.push_back('{24'sd0, 1'b1});
    pending_samples.push_back('{-24'sd1, 1'b0});
    pending_samples.push_back('{24'sd1, 1'b0});
    pending_samples.push_back('{-24'sd1, 1'b0});
    pending_samples.push_back('{24'sd100, 1'b1});
    pending_samples.push_back('{24'sd200, 1'b0});
    pending_samples.push_back('{24'sd5, 1'b1});  // restart before window fills
    pending_samples.push_back('{24'sd5, 1'b0});
    pending_samples.push_back('{24'sd5, 1'b0});
    pending_samples.push_back('{-24'sd7, 1'b0});
    pending_samples.push_back('{24'sd3, 1'b1});  // restart on a full window
    drain();

    // Write to an unmapped register index: ignored, series continues
    apb_write(3'd4, 32'd9);
    pending_samples.push_back('{24'sd11, 1'b0});
    pending_samples.push_back('{24'sd13, 1'b0});
    drain();

    // Random phases: window settings incl. 0 (acts as 1) and above 256 (clamped)
    win_list = '{1, 0, 511, 256, 2, 7, 40, 20, 0};
    cnt_list = '{150, 150, 300, 280, 150, 200, 200, 200, 150};
    win_list[7] = $urandom_range(100, 3);
    win_list[8] = $urandom_range(64, 1) | ($urandom_range(1) << 8) | 32'hFFFF_FE00;
    for (p = 0; p < 9; p++) begin
      set_idling(p % 4);
      apb_write(3'd0, win_list[p]);
      for (int i = 0; i < cnt_list[p]; i++)
        pending_samples.push_back(rand_sample(win_list[p] > 64 ? 0 : 3));
      drain();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mwms_pkg.sv
rtl/mwms_if.sv
rtl/mwms_mul.sv
rtl/mwms_div.sv
rtl/mwms_sqrt.sv
rtl/moving_window_mean_std.sv
tb/sv/tb_top.sv
